[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the PID pump controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define PIDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset cycles included.
`define PIDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pidc_pkg.sv]
// Widths, constants and codes of the PID pump speed controller.
package pidc_pkg;

  localparam int TEMP_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int SPD_W   = 10;
  localparam int MODE_W  = 4;
  localparam int INT_W   = 20;
  localparam int DER_W   = 24;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int ISUM_W  = TEMP_W + 2;
  // widest multiplicand: derivative sample minus filtered derivative
  localparam int MC_W    = DER_W + 2;
  localparam int ACC_W   = MC_W + 1;
  localparam int WW      = 28;
  localparam int FRAC    = 8;
  localparam int CNT_W   = $clog2(GAIN_W);
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int MAX_SPEED   = 1023;
  localparam int IDLE_SPEED  = 128;
  localparam int PURGE_SPEED = 1023;
  localparam int HYST_UPPER  = 20480;
  localparam int HYST_LOWER  = 20352;
  localparam int ALPHA_Q16   = 9830;
  localparam int FIELD_MAX   = 2**SPD_W - 1;

  localparam logic [GAIN_W-1:0]        ALPHA    = GAIN_W'(ALPHA_Q16);
  localparam logic signed [WW-1:0]     MAX_Q    = WW'(MAX_SPEED * 256);
  localparam logic signed [WW-1:0]     IDLE_Q   = WW'(IDLE_SPEED * 256);
  localparam logic signed [WW-1:0]     PID_TOP  =
    WW'((MAX_SPEED > FIELD_MAX) ? FIELD_MAX : MAX_SPEED);
  localparam logic [SPD_W-1:0]         FLUSH_OUT =
    SPD_W'((PURGE_SPEED > FIELD_MAX) ? FIELD_MAX : PURGE_SPEED);
  localparam logic [SPD_W-1:0]         IDLE_OUT  =
    SPD_W'((IDLE_SPEED > FIELD_MAX) ? FIELD_MAX : IDLE_SPEED);
  localparam logic signed [TEMP_W-1:0] HYST_HI  = TEMP_W'(HYST_UPPER);
  localparam logic signed [TEMP_W-1:0] HYST_LO  = TEMP_W'(HYST_LOWER);

  localparam logic signed [WW-1:0] INT_MAX = WW'(2**(INT_W-1) - 1);
  localparam logic signed [WW-1:0] INT_MIN = WW'(-(2**(INT_W-1)));
  localparam logic signed [WW-1:0] DER_MAX = WW'(2**(DER_W-1) - 1);
  localparam logic signed [WW-1:0] DER_MIN = WW'(-(2**(DER_W-1)));

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST = TEMP_W'(19968);
  localparam logic [MODE_W-1:0]        MODES_RST    = MODE_W'(5);

  typedef enum logic [ADDR_W-3:0] {
    REG_SETPOINT,
    REG_P_GAIN,
    REG_I_GAIN_STEP,
    REG_D_GAIN_RATE,
    REG_PUMP_MODES,
    REG_MANUAL_REFLUX,
    REG_MANUAL_PRODUCT
  } reg_idx_t;

  typedef enum logic [1:0] {
    PUMP_STOP,
    PUMP_ACTIVE,
    PUMP_MANUAL,
    PUMP_STOP_ALT
  } pump_mode_t;

endpackage

[rtl/core/pid_pump_speed_controller_unit.sv]
// PID pump speed controller: bit-serial PID core, pump mode selection and config registers.
//
// Input channel: one head temperature sample (in_head_temp, signed Q8.8) per beat,
// taken when in_valid is high and in_stall is low. in_stall is high while an
// update is in progress.
// Output channel: one beat per sample carrying the reflux speed, the product
// speed and the clamped PID output, held in an output register until taken.
// Sequence: after a sample is taken the controller runs two passes of the
// bit-serial multipliers, one bit of gain per cycle: the P, I and D products run
// side by side in the first pass, the derivative filter product in the second.
// A new sample is taken only after the result has gone into the output register.
// Config: APB-style port, registers at byte address 4*index, pready tied high.
// Write registers only while no update is in flight.
// Reset: synchronous, active low; registers return to their defaults, the
// controller state clears and the output register empties.
// When the receiver stalls, the finished update waits in the last step until the
// output register frees up; a new sample can be taken while a beat is pending.
module pid_pump_speed_controller_unit
  import pidc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_head_temp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SPD_W-1:0]         out_reflux_speed,
  output logic [SPD_W-1:0]         out_product_speed,
  output logic [SPD_W-1:0]         out_pid_output,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam int LANES  = 3;
  localparam int LANE_P = 0;
  localparam int LANE_I = 1;
  localparam int LANE_D = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_POST1,
    S_MUL2,
    S_DER,
    S_OUT
  } state_t;

  // configuration registers
  logic signed [TEMP_W-1:0] setpoint_r;
  logic [GAIN_W-1:0]        p_gain_r;
  logic [GAIN_W-1:0]        i_gain_r;
  logic [GAIN_W-1:0]        d_gain_r;
  logic [MODE_W-1:0]        pump_modes_r;
  logic [SPD_W-1:0]         man_reflux_r;
  logic [SPD_W-1:0]         man_product_r;

  // controller state
  logic signed [INT_W-1:0]  integral_r;
  logic signed [DER_W-1:0]  filt_r;
  logic signed [ERR_W-1:0]  last_err_r;
  logic signed [TEMP_W-1:0] last_temp_r;
  logic [SPD_W-1:0]         held_r;

  // sequencing
  state_t                   state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r;

  // working registers
  logic signed [TEMP_W-1:0] temp_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [MC_W-1:0]   mc_r  [LANES];
  logic [GAIN_W-1:0]        ml_r  [LANES];
  logic signed [ACC_W-1:0]  acc_r [LANES];
  logic [GAIN_W-1:0]        pl_r  [LANES];
  logic signed [WW-1:0]     prop_r;
  logic signed [WW-1:0]     isum_r;
  logic signed [WW-1:0]     ihi_r;
  logic signed [WW-1:0]     ilo_r;
  logic signed [WW-1:0]     psum_r;
  logic [SPD_W-1:0]         reflux_r;
  logic [SPD_W-1:0]         pid_r;

  // ---------------------------------------------------------------- config port
  reg_idx_t wr_idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r    <= SETPOINT_RST;
      p_gain_r      <= '0;
      i_gain_r      <= '0;
      d_gain_r      <= '0;
      pump_modes_r  <= MODES_RST;
      man_reflux_r  <= '0;
      man_product_r <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_SETPOINT:       setpoint_r    <= pwdata[TEMP_W-1:0];
        REG_P_GAIN:         p_gain_r      <= pwdata[GAIN_W-1:0];
        REG_I_GAIN_STEP:    i_gain_r      <= pwdata[GAIN_W-1:0];
        REG_D_GAIN_RATE:    d_gain_r      <= pwdata[GAIN_W-1:0];
        REG_PUMP_MODES:     pump_modes_r  <= pwdata[MODE_W-1:0];
        REG_MANUAL_REFLUX:  man_reflux_r  <= pwdata[SPD_W-1:0];
        REG_MANUAL_PRODUCT: man_product_r <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (wr_idx)
      REG_SETPOINT:       prdata = DATA_W'($unsigned(setpoint_r));
      REG_P_GAIN:         prdata = DATA_W'(p_gain_r);
      REG_I_GAIN_STEP:    prdata = DATA_W'(i_gain_r);
      REG_D_GAIN_RATE:    prdata = DATA_W'(d_gain_r);
      REG_PUMP_MODES:     prdata = DATA_W'(pump_modes_r);
      REG_MANUAL_REFLUX:  prdata = DATA_W'(man_reflux_r);
      REG_MANUAL_PRODUCT: prdata = DATA_W'(man_product_r);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  logic signed [ERR_W-1:0]  err_in;
  logic signed [ISUM_W-1:0] isum_in;
  logic signed [ERR_W-1:0]  dtemp_in;
  logic signed [ACC_W:0]    lane_add [LANES];
  logic signed [ACC_W:0]    lane_sum [LANES];
  logic signed [WW-1:0]     prop_w;
  logic signed [WW-1:0]     iterm_w;
  logic signed [WW-1:0]     raw_w;
  logic signed [WW-1:0]     integ_w;
  logic signed [WW-1:0]     der_w;
  logic signed [WW-1:0]     total_w;
  logic signed [WW-1:0]     quot_w;
  logic [SPD_W-1:0]         pid_w;
  logic [SPD_W-1:0]         reflux_w;
  logic [SPD_W-1:0]         product_w;
  logic                     out_load;
  state_t                   state_nxt;
  pump_mode_t               rmode;
  pump_mode_t               pmode;

  assign err_in   = ERR_W'(in_head_temp) - ERR_W'(setpoint_r);
  assign isum_in  = ISUM_W'(err_in) + ISUM_W'(last_err_r);
  assign dtemp_in = ERR_W'(in_head_temp) - ERR_W'(last_temp_r);

  // serial multiply step: add the multiplicand under the current gain bit,
  // then shift one product bit out of the accumulator
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_add[k] = ml_r[k][0] ? (ACC_W+1)'(mc_r[k]) : '0;
      lane_sum[k] = (ACC_W+1)'(acc_r[k]) + lane_add[k];
    end
  end

  // product / 256, rounded down
  assign prop_w  = WW'($signed({acc_r[LANE_P], pl_r[LANE_P][GAIN_W-1:FRAC]}));
  assign iterm_w = WW'($signed({acc_r[LANE_I], pl_r[LANE_I][GAIN_W-1:FRAC]}));
  assign raw_w   = WW'($signed({acc_r[LANE_D], pl_r[LANE_D][GAIN_W-1:FRAC]}));

  always_comb begin
    // clamp the integral so P+I stays inside the speed window, then to 20 bits
    if (isum_r > ihi_r) begin
      integ_w = ihi_r;
    end else if (isum_r < ilo_r) begin
      integ_w = ilo_r;
    end else begin
      integ_w = isum_r;
    end
    if (integ_w > INT_MAX) begin
      integ_w = INT_MAX;
    end else if (integ_w < INT_MIN) begin
      integ_w = INT_MIN;
    end

    // after the second pass the accumulator holds alpha*(raw-D) / 65536
    der_w = WW'(filt_r) + WW'(acc_r[LANE_P]);
    if (der_w > DER_MAX) begin
      der_w = DER_MAX;
    end else if (der_w < DER_MIN) begin
      der_w = DER_MIN;
    end

    total_w = psum_r + WW'(filt_r);
    quot_w  = total_w >>> FRAC;
    if (quot_w < 0) begin
      pid_w = '0;
    end else if (quot_w > PID_TOP) begin
      pid_w = SPD_W'(PID_TOP);
    end else begin
      pid_w = SPD_W'(quot_w);
    end

    rmode = pump_mode_t'(pump_modes_r[1:0]);
    pmode = pump_mode_t'(pump_modes_r[3:2]);

    case (rmode)
      PUMP_ACTIVE: reflux_w = pid_w;
      PUMP_MANUAL: reflux_w = man_reflux_r;
      default:     reflux_w = '0;
    endcase

    case (pmode)
      PUMP_ACTIVE: begin
        if (temp_r >= HYST_HI) begin
          product_w = FLUSH_OUT;
        end else if (temp_r < HYST_LO) begin
          product_w = IDLE_OUT;
        end else begin
          product_w = held_r;
        end
      end
      PUMP_MANUAL: product_w = man_product_r;
      default:     product_w = '0;
    endcase
  end

  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL1;
      S_MUL1:  if (cnt_r == CNT_W'(GAIN_W - 1)) state_nxt = S_POST1;
      S_POST1: state_nxt = S_MUL2;
      S_MUL2:  if (cnt_r == CNT_W'(GAIN_W - 1)) state_nxt = S_DER;
      S_DER:   state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      filt_r      <= '0;
      last_err_r  <= '0;
      last_temp_r <= '0;
      held_r      <= '0;
    end else begin
      state_r <= state_nxt;
      // load a new beat, else drop the one just taken
      if (state_r == S_OUT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
        end
        S_MUL1: begin
          cnt_r <= cnt_r + 1'b1;
        end
        S_POST1: begin
          cnt_r <= '0;
        end
        S_MUL2: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '0) begin
            integral_r <= INT_W'(integ_w);
          end
        end
        S_DER: begin
          filt_r <= DER_W'(der_w);
        end
        S_OUT: begin
          if (out_load) begin
            reflux_r    <= reflux_w;
            pid_r       <= pid_w;
            held_r      <= product_w;
            last_err_r  <= err_r;
            last_temp_r <= temp_r;
          end
        end
        default: ;
      endcase
    end
  end

  // multiplier lanes and intermediate terms
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          temp_r         <= in_head_temp;
          err_r          <= err_in;
          mc_r[LANE_P]   <= MC_W'(err_in);
          mc_r[LANE_I]   <= MC_W'(isum_in);
          mc_r[LANE_D]   <= MC_W'(dtemp_in);
          ml_r[LANE_P]   <= p_gain_r;
          ml_r[LANE_I]   <= i_gain_r;
          ml_r[LANE_D]   <= d_gain_r;
          for (int k = 0; k < LANES; k++) begin
            acc_r[k] <= '0;
          end
        end
      end
      S_MUL1, S_MUL2: begin
        for (int k = 0; k < LANES; k++) begin
          acc_r[k] <= lane_sum[k][ACC_W:1];
          pl_r[k]  <= {lane_sum[k][0], pl_r[k][GAIN_W-1:1]};
          ml_r[k]  <= ml_r[k] >> 1;
        end
        if (state_r == S_MUL2 && cnt_r == CNT_W'(1)) begin
          psum_r <= prop_r + WW'(integral_r);
        end
      end
      S_POST1: begin
        prop_r <= prop_w;
        isum_r <= WW'(integral_r) + iterm_w;
        ihi_r  <= (prop_w < MAX_Q) ? MAX_Q - prop_w : '0;
        ilo_r  <= (prop_w > IDLE_Q) ? IDLE_Q - prop_w : '0;
        // derivative filter: D + alpha*(raw - D) / 65536 on lane P
        mc_r[LANE_P]  <= MC_W'(raw_w - WW'(filt_r));
        ml_r[LANE_P]  <= ALPHA;
        acc_r[LANE_P] <= '0;
      end
      default: ;
    endcase
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_reflux_speed  = reflux_r;
  assign out_product_speed = held_r;
  assign out_pid_output    = pid_r;

endmodule

[rtl/core/pidc_checker.sv]
// Port-level checker for the PID pump speed controller, bound to the top level.
`include "assert_macros.svh"

module pidc_checker
  import pidc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic signed [TEMP_W-1:0] in_head_temp,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [SPD_W-1:0]         out_reflux_speed,
  input logic [SPD_W-1:0]         out_product_speed,
  input logic [SPD_W-1:0]         out_pid_output
);

  logic in_take;

  assign in_take = in_valid && !in_stall;

  // hold a stalled output beat
  `PIDC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_reflux_speed) && $stable(out_product_speed) && $stable(out_pid_output), "output beat changed while stalled")

  // one sample at a time: busy right after a sample is taken
  `PIDC_ASSERT(a_busy_after_take, in_take |=> in_stall, "input taken twice in a row")

  // a new result only comes out of a running update
  `PIDC_ASSERT(a_out_from_update, $rose(out_valid) |-> $past(in_stall), "result without a running update")

  // drop any pending beat at reset
  `PIDC_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "output valid after reset")

  // sample payload is known when taken
  `PIDC_ASSERT(a_take_known, in_take |-> !$isunknown(in_head_temp), "unknown sample taken")

endmodule

bind pid_pump_speed_controller_unit pidc_checker u_pidc_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for the PID pump speed controller unit.
`timescale 1ns / 100ps

module testbench;
  import pidc_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int         NUM_PHASES   = 10;
  localparam int         PHASE_LEN    = 130;
  localparam int         DRAIN_CYCLES = 40;
  localparam longint     MAXQ    = longint'(MAX_SPEED) * 256;
  localparam longint     IDLEQ   = longint'(IDLE_SPEED) * 256;
  localparam longint     I_TOP   = (longint'(1) << (INT_W - 1)) - 1;
  localparam longint     I_BOT   = -(longint'(1) << (INT_W - 1));
  localparam longint     D_TOP   = (longint'(1) << (DER_W - 1)) - 1;
  localparam longint     D_BOT   = -(longint'(1) << (DER_W - 1));

  typedef struct packed {
    logic [SPD_W-1:0] reflux;
    logic [SPD_W-1:0] product;
    logic [SPD_W-1:0] pid;
  } speeds_t;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_KNOWN,
    STEP_PREDICTED
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [2:0]  idx;
    logic [31:0] val;
    speeds_t     want;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_head_temp = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SPD_W-1:0]         out_reflux_speed;
  logic [SPD_W-1:0]         out_product_speed;
  logic [SPD_W-1:0]         out_pid_output;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // register mirror
  logic signed [TEMP_W-1:0] setpoint_m = SETPOINT_RST;
  logic [GAIN_W-1:0]        kp_m = '0;
  logic [GAIN_W-1:0]        ki_m = '0;
  logic [GAIN_W-1:0]        kd_m = '0;
  logic [MODE_W-1:0]        modes_m = MODES_RST;
  logic [SPD_W-1:0]         man_reflux_m = '0;
  logic [SPD_W-1:0]         man_product_m = '0;

  // controller state mirror
  longint                   integ_acc = 0;
  longint                   deriv_filt = 0;
  longint                   prev_err = 0;
  longint                   prev_temp = 0;
  logic [SPD_W-1:0]         product_hold = '0;

  speeds_t                  speeds_due [$];
  speeds_t                  head_due;
  plan_row_t                plan [$];
  bit                       calm = 1'b0;
  int                       errors = 0;
  int                       n_samples = 0;
  int                       n_checked = 0;
  int                       n_writes = 0;

  pid_pump_speed_controller_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_head_temp      (in_head_temp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reflux_speed  (out_reflux_speed),
    .out_product_speed (out_product_speed),
    .out_pid_output    (out_pid_output),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #6 clk = ~clk;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int modes_word(input pump_mode_t product, input pump_mode_t reflux);
    return int'({product, reflux});
  endfunction

  // Advance the controller mirror by one tick and return the speeds it commands.
  function automatic speeds_t advance_controller(input logic signed [TEMP_W-1:0] t);
    longint     temp, err, prop, hi, lo, integ, raw, der, pid;
    pump_mode_t rmode, pmode;
    speeds_t    res;
    temp  = longint'(t);
    err   = temp - longint'(setpoint_m);
    prop  = (longint'(kp_m) * err) >>> FRAC;
    integ = integ_acc + ((longint'(ki_m) * (err + prev_err)) >>> FRAC);
    hi    = (prop < MAXQ) ? MAXQ - prop : 0;
    lo    = (prop > IDLEQ) ? IDLEQ - prop : 0;
    if (integ > hi)
      integ = hi;
    else if (integ < lo)
      integ = lo;
    integ     = clamp(integ, I_BOT, I_TOP);
    integ_acc = integ;
    raw = (longint'(kd_m) * (temp - prev_temp)) >>> FRAC;
    der = (longint'(65536 - ALPHA_Q16) * deriv_filt + longint'(ALPHA_Q16) * raw) >>> 16;
    der = clamp(der, D_BOT, D_TOP);
    deriv_filt = der;
    pid = clamp(clamp((prop + integ + der) >>> FRAC, 0, MAX_SPEED), 0, FIELD_MAX);
    prev_err  = err;
    prev_temp = temp;

    rmode = pump_mode_t'(modes_m[1:0]);
    pmode = pump_mode_t'(modes_m[3:2]);
    case (rmode)
      PUMP_ACTIVE: res.reflux = SPD_W'(pid);
      PUMP_MANUAL: res.reflux = man_reflux_m;
      default:     res.reflux = '0;
    endcase
    case (pmode)
      PUMP_ACTIVE: begin
        if (temp >= HYST_UPPER)
          product_hold = SPD_W'(clamp(PURGE_SPEED, 0, FIELD_MAX));
        else if (temp < HYST_LOWER)
          product_hold = SPD_W'(clamp(IDLE_SPEED, 0, FIELD_MAX));
      end
      PUMP_MANUAL: product_hold = man_product_m;
      default:     product_hold = '0;
    endcase
    res.product = product_hold;
    res.pid     = SPD_W'(pid);
    return res;
  endfunction

  task automatic add_row(input step_kind_t kind, input logic [2:0] idx, input int val,
                         input int r = 0, input int p = 0, input int d = 0);
    plan_row_t row;
    row.kind = kind;
    row.idx  = idx;
    row.val  = val;
    row.want = '{reflux: SPD_W'(r), product: SPD_W'(p), pid: SPD_W'(d)};
    plan.push_back(row);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SETPOINT:       setpoint_m    = val[15:0];
      REG_P_GAIN:         kp_m          = val[15:0];
      REG_I_GAIN_STEP:    ki_m          = val[15:0];
      REG_D_GAIN_RATE:    kd_m          = val[15:0];
      REG_PUMP_MODES:     modes_m       = val[3:0];
      REG_MANUAL_REFLUX:  man_reflux_m  = val[9:0];
      REG_MANUAL_PRODUCT: man_product_m = val[9:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Offer one sample beat, with random gaps, and log its expected speeds on accept.
  task automatic send_temp(input logic signed [TEMP_W-1:0] t, input bit known,
                           input speeds_t want);
    speeds_t pred;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_head_temp <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = advance_controller(t);
    speeds_due.push_back(known ? want : pred);
    n_samples++;
  endtask

  function automatic logic [15:0] pick_setpoint();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom);
      default: return 16'(HYST_LOWER - 256 + int'($urandom_range(512)));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [9:0] pick_speed();
    case ($urandom_range(3))
      0:       return 10'd0;
      1:       return 10'd1023;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic check_field(input string what, input logic [SPD_W-1:0] want,
                             input logic [SPD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 11);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (speeds_due.size() == 0) begin
        $display("%0t: result beat with nothing expected: reflux %0d product %0d pid %0d",
                 $time, out_reflux_speed, out_product_speed, out_pid_output);
        errors++;
      end else begin
        head_due = speeds_due.pop_front();
        check_field("reflux_speed", head_due.reflux, out_reflux_speed);
        check_field("product_speed", head_due.product, out_product_speed);
        check_field("pid_output", head_due.pid, out_pid_output);
        n_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", speeds_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int          r;
    int          walk;
    logic [15:0] t;

    // Reset config: gains zero, both pumps active, so only the product hysteresis moves.
    add_row(STEP_KNOWN, 3'd0, 20400, 0, 0, 0);
    add_row(STEP_KNOWN, 3'd0, HYST_UPPER, 0, 1023, 0);
    add_row(STEP_KNOWN, 3'd0, 20400, 0, 1023, 0);
    add_row(STEP_KNOWN, 3'd0, HYST_LOWER - 1, 0, 128, 0);
    add_row(STEP_KNOWN, 3'd0, 32767, 0, 1023, 0);
    add_row(STEP_KNOWN, 3'd0, -32768, 0, 128, 0);
    add_row(STEP_KNOWN, 3'd0, HYST_LOWER, 0, 128, 0);
    add_row(STEP_KNOWN, 3'd0, HYST_UPPER - 1, 0, 128, 0);
    add_row(STEP_WRITE, REG_PUMP_MODES, modes_word(PUMP_MANUAL, PUMP_MANUAL));
    add_row(STEP_WRITE, REG_MANUAL_REFLUX, 1023);
    add_row(STEP_WRITE, REG_MANUAL_PRODUCT, 0);
    add_row(STEP_KNOWN, 3'd0, 0, 1023, 0, 0);
    add_row(STEP_WRITE, REG_MANUAL_REFLUX, 0);
    add_row(STEP_WRITE, REG_MANUAL_PRODUCT, 1023);
    add_row(STEP_KNOWN, 3'd0, -1, 0, 1023, 0);
    add_row(STEP_WRITE, REG_PUMP_MODES, modes_word(PUMP_STOP_ALT, PUMP_STOP_ALT));
    add_row(STEP_KNOWN, 3'd0, HYST_UPPER, 0, 0, 0);
    add_row(STEP_WRITE, REG_PUMP_MODES, modes_word(PUMP_STOP, PUMP_STOP));
    add_row(STEP_KNOWN, 3'd0, HYST_UPPER, 0, 0, 0);
    // unmapped index: modes must stay off
    add_row(STEP_WRITE, REG_UNMAPPED, modes_word(PUMP_ACTIVE, PUMP_ACTIVE));
    add_row(STEP_KNOWN, 3'd0, HYST_UPPER, 0, 0, 0);
    // Full gains: drive the integral into both 20-bit rails, derivative swings hard.
    add_row(STEP_WRITE, REG_PUMP_MODES, modes_word(PUMP_ACTIVE, PUMP_ACTIVE));
    add_row(STEP_WRITE, REG_SETPOINT, 0);
    add_row(STEP_WRITE, REG_P_GAIN, 65535);
    add_row(STEP_WRITE, REG_I_GAIN_STEP, 65535);
    add_row(STEP_WRITE, REG_D_GAIN_RATE, 65535);
    add_row(STEP_PREDICTED, 3'd0, -32768);
    add_row(STEP_PREDICTED, 3'd0, 2200);
    add_row(STEP_PREDICTED, 3'd0, 32767);
    add_row(STEP_PREDICTED, 3'd0, -2200);
    add_row(STEP_PREDICTED, 3'd0, 32767);
    add_row(STEP_PREDICTED, 3'd0, 0);
    add_row(STEP_PREDICTED, 3'd0, 0);
    add_row(STEP_WRITE, REG_SETPOINT, 32767);
    add_row(STEP_PREDICTED, 3'd0, -32768);
    add_row(STEP_WRITE, REG_SETPOINT, -32768);
    add_row(STEP_PREDICTED, 3'd0, 32767);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_WRITE: begin
          quiesce();
          write_reg(plan[i].idx, plan[i].val);
        end
        STEP_KNOWN: send_temp(plan[i].val[15:0], 1'b1, plan[i].want);
        default:    send_temp(plan[i].val[15:0], 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      quiesce();
      write_reg(REG_SETPOINT, 32'(pick_setpoint()));
      write_reg(REG_P_GAIN, 32'(pick_gain()));
      write_reg(REG_I_GAIN_STEP, 32'(pick_gain()));
      write_reg(REG_D_GAIN_RATE, 32'(pick_gain()));
      write_reg(REG_PUMP_MODES, $urandom_range(15));
      write_reg(REG_MANUAL_REFLUX, 32'(pick_speed()));
      write_reg(REG_MANUAL_PRODUCT, 32'(pick_speed()));
      if ($urandom_range(3) == 0)
        write_reg(REG_UNMAPPED, $urandom);
      calm = (ph == 4);
      walk = HYST_LOWER - 600 + int'($urandom_range(1200));
      for (int k = 0; k < PHASE_LEN; k++) begin
        r = int'($urandom_range(99));
        if (r < 8) begin
          t = 16'($urandom);
        end else if (r < 10) begin
          t = r[0] ? 16'h7FFF : 16'h8000;
        end else begin
          // slow drift around the hysteresis band
          walk = int'(clamp(walk + int'($urandom_range(256)) - 128, -32768, 32767));
          t = 16'(walk);
        end
        send_temp(t, 1'b0, '0);
      end
    end
    calm = 1'b0;

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d temperature samples across %0d register writes, %0d results compared",
             n_samples, n_writes, n_checked);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d field mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pidc_pkg.sv
rtl/core/pid_pump_speed_controller_unit.sv
rtl/core/pidc_checker.sv
sim/testbench.sv
